[sv/clamped_timer_alpha_fade_top_defines.svh]
// Assertion macros shared by the fade timer checker.
`ifndef CLAMPED_TIMER_ALPHA_FADE_TOP_DEFINES_SVH
`define CLAMPED_TIMER_ALPHA_FADE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define CTAF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fade timer check failed (same cycle)");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define CTAF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fade timer check failed (next cycle)");

`endif

[sv/ctaf_pkg.sv]
// Shared types and constants of the fade envelope timer.
package ctaf_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int TICK_W        = 32;
    localparam int OUT_TIME_W    = 32;
    localparam int ALPHA_W       = 8;
    localparam int Q_W           = 9;

    // divider: two steps (double, then add) per bit of the 9-bit scale
    localparam int DIV_STEPS = 2 * Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [Q_W-1:0]     K_SINGLE  = 9'd255;
    localparam logic [Q_W-1:0]     K_DOUBLE  = 9'd510;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

    // command codes
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // register indexes
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_STOP  = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    typedef enum logic [1:0] {
        MODE_IN    = 2'd0,
        MODE_OUT   = 2'd1,
        MODE_INOUT = 2'd2,
        MODE_NONE  = 2'd3
    } t_fade_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SER_A,
        ST_SER_B,
        ST_DIV,
        ST_OUT
    } t_state;

    // sequencer to bit-serial datapath
    typedef struct packed {
        logic load;
        logic phase_a;
        logic phase_b;
        logic last_b;
    } t_ser_ctrl;

    // bit-serial datapath to divider
    typedef struct packed {
        logic zero_dur;
        logic half_lt;
    } t_ser_stat;

endpackage

[sv/ctaf_regs.sv]
// APB register file: start time, stop time and fade mode.
module ctaf_regs
    import ctaf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int DATA_W    = 32,
    parameter int ADDR_W    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output logic [TIME_BITS-1:0] o_start,
    output logic [TIME_BITS-1:0] o_stop,
    output t_fade_mode           o_mode,
    output logic                 o_restart
);

    localparam int ADDR_LSB = ADDR_W - 2;

    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_stop;
    t_fade_mode           r_mode;
    logic                 r_restart;
    logic                 wr;
    logic [1:0]           idx;
    logic [TIME_BITS-1:0] rd_time;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[ADDR_LSB+1:ADDR_LSB];

    // register writes; a time write restarts the envelope on the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_stop    <= '0;
            r_mode    <= MODE_IN;
            r_restart <= 1'b0;
        end else begin
            r_restart <= wr && (idx == REG_START || idx == REG_STOP);
            if (wr) begin
                unique case (idx)
                    REG_START: r_start <= pwdata[TIME_BITS-1:0];
                    REG_STOP:  r_stop  <= pwdata[TIME_BITS-1:0];
                    REG_MODE:  r_mode  <= t_fade_mode'(pwdata[1:0]);
                    default: ;
                endcase
            end
        end
    end

    // read back
    always_comb begin
        rd_time = '0;
        prdata  = '0;
        unique case (idx)
            REG_START: begin
                rd_time = r_start;
                prdata  = DATA_W'(rd_time);
            end
            REG_STOP: begin
                rd_time = r_stop;
                prdata  = DATA_W'(rd_time);
            end
            REG_MODE: prdata = DATA_W'(r_mode);
            default:  prdata = '0;
        endcase
    end

    assign o_start   = r_start;
    assign o_stop    = r_stop;
    assign o_mode    = r_mode;
    assign o_restart = r_restart;

endmodule

[sv/ctaf_serial.sv]
// Bit-serial time datapath: saturating add, clamp, elapsed/duration/remaining.
module ctaf_serial
    import ctaf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ser_ctrl            i_ctrl,
    input  logic                 i_cmd,
    input  logic [TIME_BITS-1:0] i_tick,
    input  logic [TIME_BITS-1:0] i_start,
    input  logic [TIME_BITS-1:0] i_stop,
    input  logic                 i_restart,
    output logic [TIME_BITS-1:0] o_e,
    output logic [TIME_BITS-1:0] o_d,
    output logic [TIME_BITS-1:0] o_rem,
    output logic                 o_done,
    output t_ser_stat            o_stat
);

    typedef enum logic [1:0] {
        SRC_START,
        SRC_STOP,
        SRC_SUM
    } t_now_src;

    // LSB-first less-than: a differing bit overrides the lower bits
    function automatic logic lt_upd(input logic x, input logic y, input logic lt);
        return (x != y) ? y : lt;
    endfunction

    // one bit of x - y - borrow, returned as {borrow_out, diff}
    function automatic logic [1:0] sub_bit(input logic x, input logic y, input logic bw);
        logic d;
        logic b;
        d = x ^ y ^ bw;
        b = (~x & y) | (~(x ^ y) & bw);
        return {b, d};
    endfunction

    logic [TIME_BITS-1:0] r_sa, r_sb, r_st, r_sn, r_ss;
    logic [TIME_BITS-1:0] r_e, r_d, r_rem;
    logic r_cmd, r_carry, r_done;
    logic r_stop_lt, r_stop_eq;
    logic r_sum_lt_start, r_sum_gt_stop, r_sum_eq_stop;
    logic r_bw_e, r_bw_d, r_bw_r, r_dnz, r_lt2, r_eprev;

    logic       a, b, t, n, s, cout;
    logic       end_bit, now_bit;
    logic [1:0] se, sd, sr;
    t_now_src   src;
    logic       hit;
    logic       done_next;

    // operand bits and the serial adder
    always_comb begin
        a    = r_sa[0];
        b    = r_sb[0];
        t    = r_st[0];
        n    = r_sn[0];
        s    = n ^ t ^ r_carry;
        cout = (n & t) | (n & r_carry) | (t & r_carry);
    end

    // clamp decision from the flags of the add pass
    always_comb begin
        src = SRC_SUM;
        hit = r_sum_eq_stop;
        priority if (r_cmd == CMD_RESTART) begin
            src = SRC_START;
            hit = 1'b0;
        end else if (r_stop_lt) begin
            src = SRC_START;
            hit = 1'b1;
        end else if (r_carry) begin
            src = SRC_STOP;       // saturated sum lands on the stop time
            hit = 1'b1;
        end else if (r_sum_lt_start) begin
            src = SRC_START;
            hit = r_stop_eq;
        end else if (r_sum_gt_stop) begin
            src = SRC_STOP;
            hit = 1'b1;
        end else begin
            src = SRC_SUM;
            hit = r_sum_eq_stop;
        end
        done_next = (r_cmd == CMD_RESTART) ? 1'b0 : (r_done | hit);
    end

    // subtract pass bits
    always_comb begin
        end_bit = r_stop_lt ? a : b;
        unique case (src)
            SRC_START: now_bit = a;
            SRC_STOP:  now_bit = b;
            SRC_SUM:   now_bit = r_ss[0];
            default:   now_bit = r_ss[0];
        endcase
        se = sub_bit(now_bit, a, r_bw_e);
        sd = sub_bit(end_bit, a, r_bw_d);
        sr = sub_bit(end_bit, now_bit, r_bw_r);
    end

    // current time and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn   <= '0;
            r_done <= 1'b0;
        end else begin
            priority if (i_restart) begin
                r_sn   <= i_start;
                r_done <= 1'b0;
            end else if (i_ctrl.phase_a) begin
                r_sn <= {1'b0, r_sn[TIME_BITS-1:1]};
            end else if (i_ctrl.phase_b) begin
                r_sn <= {now_bit, r_sn[TIME_BITS-1:1]};
                if (i_ctrl.last_b) begin
                    r_done <= done_next;
                end
            end
        end
    end

    // shift registers and per-pass flags
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sa           <= i_start;
            r_sb           <= i_stop;
            r_st           <= i_tick;
            r_cmd          <= i_cmd;
            r_carry        <= 1'b0;
            r_stop_lt      <= 1'b0;
            r_stop_eq      <= 1'b1;
            r_sum_lt_start <= 1'b0;
            r_sum_gt_stop  <= 1'b0;
            r_sum_eq_stop  <= 1'b1;
            r_bw_e         <= 1'b0;
            r_bw_d         <= 1'b0;
            r_bw_r         <= 1'b0;
            r_dnz          <= 1'b0;
            r_lt2          <= 1'b0;
            r_eprev        <= 1'b0;
        end
        // add pass: sum and compares against start and stop
        if (i_ctrl.phase_a) begin
            r_sa           <= {a, r_sa[TIME_BITS-1:1]};
            r_sb           <= {b, r_sb[TIME_BITS-1:1]};
            r_st           <= {1'b0, r_st[TIME_BITS-1:1]};
            r_ss           <= {s, r_ss[TIME_BITS-1:1]};
            r_carry        <= cout;
            r_stop_lt      <= lt_upd(b, a, r_stop_lt);
            r_stop_eq      <= r_stop_eq & (a == b);
            r_sum_lt_start <= lt_upd(s, a, r_sum_lt_start);
            r_sum_gt_stop  <= lt_upd(b, s, r_sum_gt_stop);
            r_sum_eq_stop  <= r_sum_eq_stop & (s == b);
        end
        // subtract pass: elapsed, duration, remaining, 2e < d
        if (i_ctrl.phase_b) begin
            r_sa    <= {a, r_sa[TIME_BITS-1:1]};
            r_sb    <= {b, r_sb[TIME_BITS-1:1]};
            r_ss    <= {1'b0, r_ss[TIME_BITS-1:1]};
            r_e     <= {se[0], r_e[TIME_BITS-1:1]};
            r_d     <= {sd[0], r_d[TIME_BITS-1:1]};
            r_rem   <= {sr[0], r_rem[TIME_BITS-1:1]};
            r_bw_e  <= se[1];
            r_bw_d  <= sd[1];
            r_bw_r  <= sr[1];
            r_dnz   <= r_dnz | sd[0];
            r_lt2   <= lt_upd(r_eprev, sd[0], r_lt2);
            r_eprev <= se[0];
        end
    end

    // results of the subtract pass
    assign o_e             = r_e;
    assign o_d             = r_d;
    assign o_rem           = r_rem;
    assign o_done          = r_done;
    assign o_stat.zero_dur = ~r_dnz;
    // the top bit of 2e falls off the word: set means 2e >= d
    assign o_stat.half_lt  = r_lt2 & ~r_eprev;

endmodule

[sv/ctaf_div.sv]
// Iterative scaled divider, floor(k*e/d) with remainder flag, and alpha select.
module ctaf_div
    import ctaf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [TIME_BITS-1:0] i_e,
    input  logic [TIME_BITS-1:0] i_d,
    input  t_fade_mode           i_mode,
    input  t_ser_stat            i_stat,
    output logic                 o_fin,
    output logic [ALPHA_W-1:0]   o_alpha
);

    logic                 r_busy;
    logic                 r_fin;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_BITS-1:0] r_r;
    logic [Q_W-1:0]       r_q;
    logic [Q_W-1:0]       r_k;

    logic                 add_step;
    logic                 en;
    logic [TIME_BITS-1:0] addend;
    logic [TIME_BITS:0]   wide;
    logic [TIME_BITS+1:0] diff;
    logic                 ge;
    logic [TIME_BITS-1:0] n_r;
    logic                 nz;
    logic [Q_W-1:0]       q_up;

    // shared add / compare-subtract: doubling step, then add-e step
    always_comb begin
        add_step = r_cnt[0];
        en       = add_step ? r_k[Q_W-1] : 1'b1;
        addend   = add_step ? i_e : r_r;
        wide     = {1'b0, r_r} + {1'b0, addend};
        diff     = {1'b0, wide} - {2'b00, i_d};
        ge       = ~diff[TIME_BITS+1];
        n_r      = ge ? diff[TIME_BITS-1:0] : wide[TIME_BITS-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // partial remainder, quotient and scale bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= '0;
            r_q <= '0;
            r_k <= (i_mode == MODE_INOUT) ? K_DOUBLE : K_SINGLE;
        end else if (r_busy) begin
            if (add_step) begin
                r_k <= {r_k[Q_W-2:0], 1'b0};
                if (en) begin
                    r_r <= n_r;
                    r_q <= r_q + {{(Q_W-1){1'b0}}, ge};
                end
            end else begin
                r_r <= n_r;
                r_q <= {r_q[Q_W-2:0], ge};
            end
        end
    end

    // alpha for the fade mode
    always_comb begin
        nz   = |r_r;
        q_up = r_q + {{(Q_W-1){1'b0}}, nz};
        o_alpha = '0;
        unique case (i_mode)
            MODE_NONE: o_alpha = '0;
            MODE_IN:   o_alpha = i_stat.zero_dur ? ALPHA_MAX : r_q[ALPHA_W-1:0];
            MODE_OUT:  o_alpha = i_stat.zero_dur ? '0 : ALPHA_MAX - q_up[ALPHA_W-1:0];
            MODE_INOUT: begin
                if (i_stat.zero_dur) begin
                    o_alpha = '0;
                end else if (i_stat.half_lt) begin
                    o_alpha = r_q[ALPHA_W-1:0];
                end else begin
                    o_alpha = ALPHA_W'(K_DOUBLE - q_up);
                end
            end
            default: o_alpha = '0;
        endcase
    end

    assign o_fin = r_fin;

endmodule

[sv/clamped_timer_alpha_fade_top.sv]
// Top level of the fade envelope timer: sequencer, datapath and result register.
//
// Each accepted item (advance by a tick amount, or restart) updates the current
// time and returns one result with alpha, the done flag, elapsed and remaining
// time. To form the result, the time word goes twice through a one-bit-per-cycle
// datapath (saturating add with clamp compares, then the three subtractions),
// followed by an 18-step divider (one double and one add step per bit of the
// scale factor); the divider's finish flag is registered, and the result is then
// loaded into the output register. The next item is taken the cycle after the
// result is loaded, so no new item is accepted while one is in flight; a
// result still waiting in the output register holds the next item back until
// the consumer takes it. Writing the start or stop time restarts the
// envelope; writing the fade mode does not.
module clamped_timer_alpha_fade_top
    import ctaf_pkg::*;
#(
    parameter  int TIME_BITS  = TIME_BITS_DEF,
    localparam int APB_DATA_W = (TIME_BITS > 32) ? 64 : 32,
    localparam int APB_ADDR_W = (TIME_BITS > 32) ? 5 : 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [TICK_W-1:0]     i_tick_amount,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ALPHA_W-1:0]    o_alpha,
    output logic                  o_done_res,
    output logic [OUT_TIME_W-1:0] o_elapsed,
    output logic [OUT_TIME_W-1:0] o_remaining
);

    localparam int CNT_W = $clog2(TIME_BITS);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 cnt_last;
    t_ser_ctrl            ctrl;
    t_ser_stat            stat;
    logic                 out_load;

    logic [TIME_BITS-1:0] start_t, stop_t, tick_t;
    t_fade_mode           mode;
    logic                 restart;
    logic [TIME_BITS-1:0] e_t, d_t, rem_t;
    logic                 done_t;
    logic                 div_fin;
    logic [ALPHA_W-1:0]   alpha_t;

    logic                  r_out_valid;
    logic [ALPHA_W-1:0]    r_alpha;
    logic                  r_done_res;
    logic [OUT_TIME_W-1:0] r_elapsed;
    logic [OUT_TIME_W-1:0] r_remaining;

    assign tick_t = TIME_BITS'(i_tick_amount);

    ctaf_regs #(
        .TIME_BITS (TIME_BITS),
        .DATA_W    (APB_DATA_W),
        .ADDR_W    (APB_ADDR_W)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_start   (start_t),
        .o_stop    (stop_t),
        .o_mode    (mode),
        .o_restart (restart)
    );

    ctaf_serial #(
        .TIME_BITS (TIME_BITS)
    ) u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_cmd     (i_cmd),
        .i_tick    (tick_t),
        .i_start   (start_t),
        .i_stop    (stop_t),
        .i_restart (restart),
        .o_e       (e_t),
        .o_d       (d_t),
        .o_rem     (rem_t),
        .o_done    (done_t),
        .o_stat    (stat)
    );

    ctaf_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.last_b),
        .i_e     (e_t),
        .i_d     (d_t),
        .i_mode  (mode),
        .i_stat  (stat),
        .o_fin   (div_fin),
        .o_alpha (alpha_t)
    );

    assign cnt_last = (r_cnt == CNT_W'(TIME_BITS - 1));

    // state register and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SER_A || r_state == ST_SER_B) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        out_load     = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.phase_a = 1'b0;
        ctrl.phase_b = 1'b0;
        ctrl.last_b  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ctrl.load  = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_SER_A;
                end
            end
            ST_SER_A: begin
                ctrl.phase_a = 1'b1;
                if (cnt_last) begin
                    n_state = ST_SER_B;
                end
            end
            ST_SER_B: begin
                ctrl.phase_b = 1'b1;
                ctrl.last_b  = cnt_last;
                if (cnt_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_fin) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_alpha     <= alpha_t;
            r_done_res  <= done_t;
            r_elapsed   <= OUT_TIME_W'(e_t);
            r_remaining <= OUT_TIME_W'(rem_t);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_alpha     = r_alpha;
    assign o_done_res  = r_done_res;
    assign o_elapsed   = r_elapsed;
    assign o_remaining = r_remaining;

endmodule

[sv/ctaf_checker.sv]
// Port-level checks of the fade envelope timer, bound to the top level.
`include "clamped_timer_alpha_fade_top_defines.svh"

module ctaf_checker
    import ctaf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_done_res,
    input logic [OUT_TIME_W-1:0] o_remaining
);

    // a waiting result is not dropped
    `CTAF_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // one item in flight: no transfer on the cycle after a transfer
    `CTAF_ASSERT_NXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready)

    // a fresh item cannot produce its result on the next cycle
    `CTAF_ASSERT_NXT(a_no_early, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid)

    // once the stop time is reached the time stays there: a done result has no remaining time
    `CTAF_ASSERT_IMP(a_done_rem, o_out_valid && o_done_res, o_remaining == '0)

endmodule

bind clamped_timer_alpha_fade_top ctaf_checker u_ctaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_done_res  (o_done_res),
    .o_remaining (o_remaining)
);

[sim/clamped_timer_alpha_fade_top_tb.sv]
// Self-checking testbench of the fade envelope timer: APB setup, tick stream, scoreboard.
`timescale 1ns / 1ps

module clamped_timer_alpha_fade_top_tb;
    import ctaf_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         NUM_PHASES  = 15;
    localparam int         PHASE_ITEMS = 120;

    // one expected result of the timer
    typedef struct packed {
        logic [ALPHA_W-1:0]    alpha;
        logic                  done_res;
        logic [OUT_TIME_W-1:0] elapsed;
        logic [OUT_TIME_W-1:0] remaining;
    } t_fade_frame;

    // Envelope predictor plus the queue of frames still owed by the block
    class fade_scoreboard;
        logic [31:0]  start_time;
        logic [31:0]  stop_time;
        logic [31:0]  now_time;
        logic         done_flag;
        t_fade_mode   mode;
        t_fade_frame  owed_frames[$];
        int           errors;

        function new();
            start_time = '0;
            stop_time  = '0;
            now_time   = '0;
            done_flag  = 1'b0;
            mode       = MODE_IN;
            errors     = 0;
        endfunction

        function int pending();
            return owed_frames.size();
        endfunction

        // register write; time registers restart the envelope
        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_START: begin
                    start_time = val;
                    now_time   = val;
                    done_flag  = 1'b0;
                end
                REG_STOP: begin
                    stop_time = val;
                    now_time  = start_time;
                    done_flag = 1'b0;
                end
                REG_MODE: mode = t_fade_mode'(val[1:0]);
                default: ;
            endcase
        endfunction

        function logic [31:0] eff_stop();
            return (stop_time < start_time) ? start_time : stop_time;
        endfunction

        // exact-division alpha for elapsed e over duration d
        function logic [7:0] alpha_for(logic [31:0] e, logic [31:0] d);
            logic [63:0] e64;
            logic [63:0] d64;
            logic [63:0] num;
            logic [63:0] fl;
            logic [63:0] cl;
            e64 = {32'd0, e};
            d64 = {32'd0, d};
            if (mode == MODE_NONE) return 8'd0;
            if (d == 0) return (mode == MODE_IN) ? ALPHA_MAX : 8'd0;
            num = (mode == MODE_INOUT) ? 64'd510 * e64 : 64'd255 * e64;
            fl  = num / d64;
            cl  = (num + d64 - 64'd1) / d64;
            case (mode)
                MODE_IN:  return fl[7:0];
                MODE_OUT: return 8'(64'd255 - cl);
                default: begin
                    if ((e64 << 1) < d64) return fl[7:0];
                    return 8'(64'd510 - cl);
                end
            endcase
        endfunction

        // accepted input transfer: update time, queue the owed frame
        function void take_item(logic cmd, logic [31:0] tick);
            logic [31:0] endv;
            logic [32:0] sum;
            logic [31:0] t;
            t_fade_frame f;
            endv = eff_stop();
            if (cmd == CMD_RESTART) begin
                now_time  = start_time;
                done_flag = 1'b0;
            end else begin
                sum = {1'b0, now_time} + {1'b0, tick};
                t   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (t < start_time) t = start_time;
                if (t > endv) t = endv;
                now_time = t;
                if (now_time == endv) done_flag = 1'b1;
            end
            f.elapsed   = now_time - start_time;
            f.remaining = endv - now_time;
            f.done_res  = done_flag;
            f.alpha     = alpha_for(f.elapsed, endv - start_time);
            owed_frames.push_back(f);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 100)
                $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
            errors++;
        endtask

        // output transfer: compare against the oldest owed frame
        task check_frame(logic [7:0] alpha, logic done_res, logic [31:0] elapsed,
                         logic [31:0] remaining);
            t_fade_frame f;
            if (owed_frames.size() == 0) begin
                report_mismatch("unexpected result", elapsed, 32'd0);
            end else begin
                f = owed_frames.pop_front();
                if (alpha !== f.alpha)
                    report_mismatch("alpha", 32'(alpha), 32'(f.alpha));
                if (done_res !== f.done_res)
                    report_mismatch("done", 32'(done_res), 32'(f.done_res));
                if (elapsed !== f.elapsed) report_mismatch("elapsed", elapsed, f.elapsed);
                if (remaining !== f.remaining)
                    report_mismatch("remaining", remaining, f.remaining);
            end
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic        i_cmd         = CMD_ADVANCE;
    logic [31:0] i_tick_amount = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_alpha;
    logic        o_done_res;
    logic [31:0] o_elapsed;
    logic [31:0] o_remaining;

    int send_idle_pct = 31;
    int recv_idle_pct = 76;

    fade_scoreboard sb;

    clamped_timer_alpha_fade_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_tick_amount (i_tick_amount),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_alpha       (o_alpha),
        .o_done_res    (o_done_res),
        .o_elapsed     (o_elapsed),
        .o_remaining   (o_remaining)
    );

    always #5 i_clk = ~i_clk;

    // result side: check each transfer, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_frame(o_alpha, o_done_res, o_elapsed, o_remaining);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // APB write: setup cycle, access cycle, then a bus-idle cycle
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // APB read with readback compare
    task automatic apb_read(input logic [1:0] idx, input logic [31:0] want);
        paddr   <= {idx, 2'b00};
        pwrite  <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) sb.report_mismatch("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off input until every owed frame has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // one input transfer, then random sender idle cycles
    task automatic send_item(input logic cmd, input logic [31:0] tick);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_tick_amount <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_item(cmd, tick);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_envelope(input logic [31:0] start, input logic [31:0] stop,
                                input t_fade_mode mode);
        wait_drained();
        apb_write(REG_START, start);
        apb_write(REG_STOP, stop);
        apb_write(REG_MODE, {30'd0, mode});
        apb_read(REG_START, start);
        apb_read(REG_STOP, stop);
        apb_read(REG_MODE, {30'd0, mode});
    endtask

    task automatic set_mode_only(input t_fade_mode mode);
        wait_drained();
        apb_write(REG_MODE, {30'd0, mode});
    endtask

    // random envelope, then a stream of mostly advances with scaled ticks
    task automatic run_random_phase(input int p);
        logic [31:0] s;
        logic [31:0] dur;
        logic [31:0] st;
        logic [32:0] sum;
        logic [31:0] span;
        logic [31:0] tick;
        int k;
        int r;
        k = $urandom_range(3);
        case (k)
            0:       s = 32'd0;
            1:       s = $urandom_range(1000);
            2:       s = $urandom;
            default: s = 32'hFFFF_FFFF - $urandom_range(5000);
        endcase
        k = $urandom_range(9);
        case (k)
            0:       dur = 32'd0;
            1:       dur = $urandom_range(3, 1);
            7, 8:    dur = $urandom;
            9:       dur = 32'hFFFF_FFFF;
            default: dur = $urandom_range(2000, 4);
        endcase
        sum = {1'b0, s} + {1'b0, dur};
        st  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        // stop below start now and then
        if ($urandom_range(7) == 0 && s != 0) st = $urandom_range(s - 1, 0);
        set_envelope(s, st, t_fade_mode'(p % 4));
        span = (sb.eff_stop() - s) / 8 + 1;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2 && p % 3 == 0) wait_drained();
            r = $urandom_range(99);
            if (r < 6) begin
                send_item(CMD_RESTART, $urandom);
            end else begin
                if (r < 14)      tick = $urandom;
                else if (r < 18) tick = 32'd0;
                else             tick = $urandom_range(span);
                send_item(CMD_ADVANCE, tick);
            end
        end
    endtask

    // run time limit
    initial begin
        #(64'd20_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero duration, first advance latches done
        send_item(CMD_ADVANCE, 32'd0);
        send_item(CMD_RESTART, 32'd0);

        // full range, overflow on the add
        set_envelope(32'd0, 32'hFFFF_FFFF, MODE_IN);
        send_item(CMD_ADVANCE, 32'h7FFF_FFFF);
        send_item(CMD_ADVANCE, 32'h8000_0000);
        send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
        send_item(CMD_RESTART, 32'hFFFF_FFFF);
        send_item(CMD_ADVANCE, 32'hFFFF_FFFF);

        // window at the top of the time range, saturating sum
        set_envelope(32'hFFFF_FF00, 32'hFFFF_FFFF, MODE_OUT);
        send_item(CMD_ADVANCE, 32'h0000_0080);
        send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
        send_item(CMD_RESTART, 32'd0);

        // mode write keeps the current time; in-out around the half point
        set_mode_only(MODE_INOUT);
        send_item(CMD_ADVANCE, 32'h0000_007F);
        send_item(CMD_ADVANCE, 32'd1);
        send_item(CMD_ADVANCE, 32'd0);

        // stop below start
        set_envelope(32'd100, 32'd50, MODE_INOUT);
        send_item(CMD_ADVANCE, 32'd0);
        send_item(CMD_RESTART, 32'd5);

        // no fade, then zero duration in fade out and in-out
        set_envelope(32'd5, 32'd9, MODE_NONE);
        send_item(CMD_ADVANCE, 32'd3);
        set_envelope(32'd7, 32'd7, MODE_OUT);
        send_item(CMD_ADVANCE, 32'd0);
        set_mode_only(MODE_INOUT);
        send_item(CMD_ADVANCE, 32'd0);

        // write to an unused index is ignored
        wait_drained();
        apb_write(REG_UNUSED, $urandom);
        send_item(CMD_ADVANCE, 32'd1);

        // random phases under three idle regimes
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 76;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(p);
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/ctaf_pkg.sv
sv/ctaf_regs.sv
sv/ctaf_serial.sv
sv/ctaf_div.sv
sv/clamped_timer_alpha_fade_top.sv
sv/ctaf_checker.sv
sim/clamped_timer_alpha_fade_top_tb.sv
